>>> rtl/f2dt_pkg.sv
// Shared types, constants and character tables for the float-to-decimal-text block.
`default_nettype none
package f2dt_pkg;

    // Binary32 field handling
    localparam logic [7:0] EXP_ALL_ONES  = 8'hFF;
    localparam logic [7:0] EXP_INT_BASE  = 8'd150;  // exponent at which the unit bit is LSB
    localparam logic [7:0] EXP_OVF       = 8'd159;  // first exponent whose integer part overflows
    localparam logic [7:0] FRAC_LIMIT    = 8'd35;   // right shift at which no fraction digit is left
    localparam logic [7:0] FRAC_WIDE     = 8'd24;   // right shift at which the whole significand is fraction
    localparam logic [6:0] FRAC_SCALE    = 7'd125;  // 1000 / 8

    // Division by ten through a reciprocal
    localparam logic [31:0] RECIP_TEN       = 32'hCCCC_CCCD;
    localparam int          RECIP_TEN_SHIFT = 35;

    // Digit buffer: three fraction digits, then up to ten integer digits
    localparam int DIG_DEPTH    = 13;
    localparam int DIG_IDX_W    = $clog2(DIG_DEPTH);
    localparam logic [DIG_IDX_W-1:0] FRAC_TOP_IDX = DIG_IDX_W'(2);
    localparam logic [DIG_IDX_W-1:0] INT_LOW_IDX  = DIG_IDX_W'(3);

    localparam int QUEUE_DEPTH_DEF = 2;

    // Character codes
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_NL    = 7'h0A;

    typedef enum logic [1:0] {
        KIND_NUM,
        KIND_NAN,
        KIND_INF,
        KIND_OVF
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic [31:0] ipart;
        logic [9:0]  dpart;
    } t_entry;

    typedef struct packed {
        logic   avail;
        t_entry head;
    } t_queue_rd;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CONV,
        BK_SIGN,
        BK_INT,
        BK_DOT,
        BK_FRAC,
        BK_TEXT,
        BK_NL
    } t_back_state;

    // Index of the final letter of a fixed word
    function automatic logic [DIG_IDX_W-1:0] text_last(input t_kind kind);
        logic [DIG_IDX_W-1:0] r;
        case (kind)
            KIND_OVF: r = DIG_IDX_W'(7);
            default:  r = DIG_IDX_W'(2);
        endcase
        return r;
    endfunction

    // Letters of "NaN", "Inf" and "Overflow"
    function automatic logic [6:0] text_char(input t_kind kind,
                                             input logic [DIG_IDX_W-1:0] idx);
        logic [6:0] c;
        c = CH_NL;
        case (kind)
            KIND_NAN: begin
                case (idx)
                    4'd0:    c = 7'h4E;  // N
                    4'd1:    c = 7'h61;  // a
                    default: c = 7'h4E;  // N
                endcase
            end
            KIND_INF: begin
                case (idx)
                    4'd0:    c = 7'h49;  // I
                    4'd1:    c = 7'h6E;  // n
                    default: c = 7'h66;  // f
                endcase
            end
            KIND_OVF: begin
                case (idx)
                    4'd0:    c = 7'h4F;  // O
                    4'd1:    c = 7'h76;  // v
                    4'd2:    c = 7'h65;  // e
                    4'd3:    c = 7'h72;  // r
                    4'd4:    c = 7'h66;  // f
                    4'd5:    c = 7'h6C;  // l
                    4'd6:    c = 7'h6F;  // o
                    default: c = 7'h77;  // w
                endcase
            end
            default: c = CH_NL;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/f2dt_front.sv
// Front end: takes a binary32 word, classifies it and splits it into integer and milli parts.
`default_nettype none
module f2dt_front (
    input  wire logic           i_valid,
    input  wire logic [31:0]    i_value_bits,
    input  wire logic           i_full,
    output logic                o_stall,
    output logic                o_wr,
    output f2dt_pkg::t_entry    o_entry
);
    import f2dt_pkg::*;

    logic        sign;
    logic [7:0]  ex;
    logic [22:0] mant;
    logic [23:0] sig;
    logic [7:0]  fs;
    logic [3:0]  sh;
    logic [23:0] frac;
    logic [30:0] scaled;
    logic [33:0] scaled_x8;
    logic [33:0] dq;
    logic [31:0] ipart;
    logic [9:0]  dpart;

    assign sign = i_value_bits[31];
    assign ex   = i_value_bits[30:23];
    assign mant = i_value_bits[22:0];
    assign sig  = {1'b1, mant};
    assign fs   = EXP_INT_BASE - ex;
    assign sh   = 4'(ex - EXP_INT_BASE);

    // Fraction bits of the significand, scaled by 1000 and cut to whole thousandths
    always_comb begin
        if (fs >= FRAC_WIDE) begin
            frac = sig;
        end else begin
            frac = sig & ~(24'hFF_FFFF << fs[4:0]);
        end
        scaled    = 31'(frac) * 31'(FRAC_SCALE);
        scaled_x8 = {scaled, 3'b000};
        dq        = scaled_x8 >> fs[5:0];
    end

    always_comb begin
        ipart = '0;
        dpart = '0;
        if (ex >= EXP_INT_BASE) begin
            ipart = {8'b0, sig} << sh;
        end else if (ex != 8'd0) begin
            if (fs < FRAC_WIDE) begin
                ipart = {8'b0, sig >> fs[4:0]};
            end
            if (fs < FRAC_LIMIT) begin
                dpart = dq[9:0];
            end
        end
    end

    always_comb begin
        o_entry       = '0;
        o_entry.ipart = ipart;
        o_entry.dpart = dpart;
        if (ex == EXP_ALL_ONES) begin
            o_entry.kind  = (mant != '0) ? KIND_NAN : KIND_INF;
            o_entry.neg   = (mant == '0) && sign;
        end else if (ex >= EXP_OVF) begin
            o_entry.kind  = KIND_OVF;
            o_entry.neg   = sign;
        end else begin
            // a zero result carries no sign
            o_entry.kind  = KIND_NUM;
            o_entry.neg   = sign && ((ipart != '0) || (dpart != '0));
        end
    end

    assign o_stall = i_full;
    assign o_wr    = i_valid && !i_full;

endmodule
`default_nettype wire

>>> rtl/f2dt_queue.sv
// Short queue of classified values between the front end and the text generator.
`default_nettype none
module f2dt_queue #(
    parameter int DEPTH = f2dt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr,
    input  wire f2dt_pkg::t_entry   i_entry,
    input  wire logic               i_pop,
    output logic                    o_full,
    output f2dt_pkg::t_queue_rd     o_rd
);
    import f2dt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full        = (r_count == CNT_FULL);
    assign o_rd.avail    = (r_count != '0);
    assign o_rd.head     = r_mem[r_rd_ptr];
    assign do_pop        = i_pop && o_rd.avail;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_wr, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/f2dt_back.sv
// Back end: turns a classified value into decimal digits and streams its characters.
`default_nettype none
module f2dt_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire f2dt_pkg::t_queue_rd    i_rd,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [6:0]                  o_char_code,
    output logic                        o_last_char
);
    import f2dt_pkg::*;

    t_back_state           r_state;
    t_back_state           n_state;
    t_kind                 r_kind;
    logic                  r_neg;
    logic [31:0]           r_work;
    logic [31:0]           r_ipart;
    logic [DIG_IDX_W-1:0]  r_cnt;
    logic [DIG_IDX_W-1:0]  r_idx;
    logic [3:0]            r_dig [DIG_DEPTH];
    logic                  r_o_valid;
    logic [6:0]            r_o_char;
    logic                  r_o_last;

    logic [63:0] prod;
    logic [28:0] quot;
    logic [31:0] q_times_ten;
    logic [3:0]  rem;
    logic        conv_done;
    logic        emit_en;
    logic        advance;
    logic [6:0]  emit_char;
    logic        emit_last;

    // One decimal digit per cycle: quotient by reciprocal, remainder by shift-add
    assign prod        = {32'b0, r_work} * {32'b0, RECIP_TEN};
    assign quot        = prod[63:RECIP_TEN_SHIFT];
    assign q_times_ten = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem         = 4'(r_work - q_times_ten);
    assign conv_done   = (r_cnt >= INT_LOW_IDX) && (quot == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_rd.avail) begin
                    if (i_rd.head.kind == KIND_NUM) begin
                        n_state = BK_CONV;
                    end else if (i_rd.head.neg) begin
                        n_state = BK_SIGN;
                    end else begin
                        n_state = BK_TEXT;
                    end
                end
            end
            BK_CONV: begin
                if (conv_done) begin
                    n_state = r_neg ? BK_SIGN : BK_INT;
                end
            end
            BK_SIGN: begin
                if (advance) begin
                    n_state = (r_kind == KIND_NUM) ? BK_INT : BK_TEXT;
                end
            end
            BK_INT: begin
                if (advance && (r_idx == INT_LOW_IDX)) begin
                    n_state = BK_DOT;
                end
            end
            BK_DOT: begin
                if (advance) begin
                    n_state = BK_FRAC;
                end
            end
            BK_FRAC: begin
                if (advance && (r_idx == '0)) begin
                    n_state = BK_NL;
                end
            end
            BK_TEXT: begin
                if (advance && (r_idx == text_last(r_kind))) begin
                    n_state = BK_NL;
                end
            end
            BK_NL: begin
                if (advance) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        emit_en   = 1'b1;
        emit_char = CH_NL;
        emit_last = 1'b0;
        case (r_state)
            BK_SIGN: emit_char = CH_MINUS;
            BK_INT:  emit_char = CH_ZERO + {3'b000, r_dig[r_idx]};
            BK_DOT:  emit_char = CH_DOT;
            BK_FRAC: emit_char = CH_ZERO + {3'b000, r_dig[r_idx]};
            BK_TEXT: emit_char = text_char(r_kind, r_idx);
            BK_NL:   emit_last = 1'b1;
            default: emit_en   = 1'b0;
        endcase
    end

    assign advance = emit_en && (!r_o_valid || !i_stall);
    assign o_pop   = (r_state == BK_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_kind  <= i_rd.head.kind;
                r_neg   <= i_rd.head.neg;
                r_work  <= {22'b0, i_rd.head.dpart};
                r_ipart <= i_rd.head.ipart;
                r_cnt   <= '0;
                r_idx   <= '0;
            end
            BK_CONV: begin
                r_dig[r_cnt] <= rem;
                r_work       <= (r_cnt == FRAC_TOP_IDX) ? r_ipart : {3'b000, quot};
                r_cnt        <= r_cnt + 1'b1;
                if (conv_done) begin
                    r_idx <= r_cnt;
                end
            end
            BK_INT, BK_FRAC: begin
                if (advance) begin
                    r_idx <= r_idx - 1'b1;
                end
            end
            BK_TEXT: begin
                if (advance) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_char <= emit_char;
            r_o_last <= emit_last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_char_code = r_o_char;
    assign o_last_char = r_o_last;

endmodule
`default_nettype wire

>>> rtl/float32_to_decimal_text_unit.sv
// Top level: binary32 to three-place decimal ASCII text converter.
//
// Input channel: i_in_valid / o_in_stall with i_value_bits. A transfer takes
// place at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall with o_char_code and o_last_char.
// One character leaves per transfer; o_last_char marks the closing newline.
//
// The front end classifies a word in the cycle of its transfer and writes it
// into a short queue (QUEUE_DEPTH entries); o_in_stall is high only while
// that queue is full. The back end pops one entry, then for an ordinary
// number runs one divide-by-ten step per cycle: three fraction digits and
// one to ten integer digits. Characters then leave at one per cycle while
// i_out_stall is low, from a single output register, up to 16 per value.
// A number goes through its digit steps and then its characters; NaN, Inf
// and Overflow go straight to their characters.
// The divide-by-ten loop and the one-character-per-cycle output set the rate.
//
// Synchronous reset empties the queue, returns the sequencer to idle and
// drops o_out_valid. While i_out_stall is high the shown character holds and
// the sequencer waits to emit; the queue keeps taking words until it fills.
`default_nettype none
module float32_to_decimal_text_unit #(
    parameter int QUEUE_DEPTH = f2dt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_value_bits,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [6:0]       o_char_code,
    output logic             o_last_char
);
    import f2dt_pkg::*;

    logic      queue_full;
    logic      queue_wr;
    logic      queue_pop;
    t_entry    front_entry;
    t_queue_rd queue_rd;

    // Classify on transfer, push into the queue
    f2dt_front u_front (
        .i_valid      (i_in_valid),
        .i_value_bits (i_value_bits),
        .i_full       (queue_full),
        .o_stall      (o_in_stall),
        .o_wr         (queue_wr),
        .o_entry      (front_entry)
    );

    // Decouple the two sides
    f2dt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (queue_wr),
        .i_entry (front_entry),
        .i_pop   (queue_pop),
        .o_full  (queue_full),
        .o_rd    (queue_rd)
    );

    // Convert digits and stream characters
    f2dt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (queue_rd),
        .o_pop       (queue_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule
`default_nettype wire

>>> rtl/f2dt_checker.sv
// Port-level checks for the converter, bound to the top level.
`default_nettype none
module f2dt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [6:0] o_char_code,
    input wire logic       o_last_char
);
    import f2dt_pkg::*;

    // Hold a stalled character
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_char_code) && $stable(o_last_char))
        else $error("stalled output changed");

    // Drop output after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // The end marker goes with the newline and only with it
    a_last_is_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_char == (o_char_code == CH_NL)))
        else $error("end marker and newline disagree");

    // Every other character is a sign, point, digit or letter
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_char |-> (o_char_code >= CH_MINUS) && (o_char_code <= 7'h77))
        else $error("character outside the text set");

endmodule

bind float32_to_decimal_text_unit f2dt_checker u_f2dt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_char_code (o_char_code),
    .o_last_char (o_last_char)
);
`default_nettype wire
